// ----- rtl/assert_macros.svh -----
// assertion macros shared by the receive ring buffer rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RRB_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define RRB_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define RRB_ASSERT(label, clk, rst_n, prop)
`define RRB_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ----- rtl/rrb_pkg.sv -----
// types, codes and constants of the receive ring buffer
// no dependencies; used by the interfaces and the core
`default_nettype none
package rrb_pkg;

	localparam int DEPTH = 256;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = (PTR_W > 8) ? PTR_W : 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [1:0] {
		OP_RECEIVE = 2'd0,
		OP_TICK    = 2'd1,
		OP_READ    = 2'd2
	} op_t;

	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MATCH_SYMBOL  = CFG_IDX_W'(1);

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       read_valid;
		logic       timeout_event;
		logic [7:0] pending_count;
		logic       link_busy;
		logic [7:0] newest_byte;
		logic       newest_matches;
	} out_item_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] value;
	} cfg_wr_t;

	function automatic logic [7:0] sat_count(input logic [PTR_W-1:0] cnt);
		logic [CNT_W-1:0] wide;
		wide = CNT_W'(cnt);
		return (wide > CNT_W'(255)) ? 8'hFF : wide[7:0];
	endfunction

endpackage
`default_nettype wire

// ----- rtl/rrb_ifs.sv -----
// valid/ready channel interfaces: input items, results, config writes
// depends on rrb_pkg for the payload types
`default_nettype none
interface rrb_in_if;
	logic              valid;
	logic              ready;
	rrb_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rrb_out_if;
	logic               valid;
	logic               ready;
	rrb_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rrb_cfg_if;
	logic             valid;
	logic             ready;
	rrb_pkg::cfg_wr_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/rrb_ram.sv -----
// generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none
module rrb_ram #(
	parameter int DW = 8,
	parameter int WORDS = 256,
	parameter int AW = $clog2(WORDS)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);
	logic [DW-1:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ----- rtl/rx_ring_buffer_with_idle_timeout_core.sv -----
// receive ring buffer with idle timeout, top level
// depends on rrb_pkg, rrb_ifs, rrb_ram and assert_macros.svh
//
// channel | dir | payload                                   | transfer when
// req     | in  | operation, rx_byte                        | valid & ready
// rsp     | out | read_byte .. newest_matches               | valid & ready
// cfg     | in  | index, value (0 timeout_ticks, 1 match)   | valid & ready
//
// receive, tick and empty read: result registered at the transfer
// read of a stored byte: the ram read is registered first, then the result in ST_READ
// req.ready drops while a read waits on the ram or a result is held unread
// cfg is always ready; arst_n clears state, pointers, counters and config registers
// the byte store has no reset and no clearing pass
`default_nettype none
`include "assert_macros.svh"
module rx_ring_buffer_with_idle_timeout_core (
	input wire logic clk,
	input wire logic arst_n,
	rrb_in_if.sink   req,
	rrb_out_if.source rsp,
	rrb_cfg_if.sink  cfg
);
	localparam logic [rrb_pkg::PTR_W-1:0] LAST_POS = rrb_pkg::PTR_W'(rrb_pkg::DEPTH - 1);
	localparam logic [rrb_pkg::PTR_W:0] DEPTH_X = (rrb_pkg::PTR_W + 1)'(rrb_pkg::DEPTH);

	rrb_pkg::state_t state_q, state_nxt;
	logic [rrb_pkg::PTR_W-1:0] wp_q, wp_nxt;
	logic [rrb_pkg::PTR_W-1:0] unread_q, unread_nxt;
	logic [15:0] idle_q, idle_nxt;
	logic [7:0] newest_q, newest_nxt;
	logic [15:0] timeout_q;
	logic [7:0] match_q;
	logic out_valid_q;
	rrb_pkg::out_item_t out_q, out_d;
	logic out_load;
	logic accept;
	logic rd_go, mem_we, tevent;
	logic [rrb_pkg::PTR_W:0] rd_sum;
	logic [rrb_pkg::PTR_W-1:0] rd_addr;
	logic [7:0] mem_rdata;
	logic [7:0] newest_out;
	rrb_pkg::op_t op;

	assign op = rrb_pkg::op_t'(req.data.operation);
	assign accept = req.valid & req.ready;
	assign req.ready = (state_q == rrb_pkg::ST_IDLE) && (!out_valid_q || rsp.ready);
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_valid_q;
	assign rsp.data = out_q;

	// oldest unread entry: write position minus unread count, modulo depth
	assign rd_sum = {1'b0, wp_q} + ((wp_q < unread_q) ? DEPTH_X : '0) - {1'b0, unread_q};
	assign rd_addr = rd_sum[rrb_pkg::PTR_W-1:0];

	always_comb begin
		wp_nxt = wp_q;
		unread_nxt = unread_q;
		idle_nxt = idle_q;
		newest_nxt = newest_q;
		tevent = 1'b0;
		rd_go = 1'b0;
		mem_we = 1'b0;
		if (accept) begin
			case (op)
				rrb_pkg::OP_RECEIVE: begin
					mem_we = 1'b1;
					idle_nxt = timeout_q;
					newest_nxt = req.data.rx_byte;
					if (unread_q != LAST_POS) begin
						unread_nxt = unread_q + 1'b1;
					end
					wp_nxt = (wp_q == LAST_POS) ? '0 : wp_q + 1'b1;
				end
				rrb_pkg::OP_TICK: begin
					if (idle_q != 16'd0) begin
						idle_nxt = idle_q - 16'd1;
						tevent = (idle_q == 16'd1);
					end
				end
				rrb_pkg::OP_READ: begin
					if (unread_q != '0) begin
						rd_go = 1'b1;
						unread_nxt = unread_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	rrb_ram #(
		.DW(8),
		.WORDS(rrb_pkg::DEPTH),
		.AW(rrb_pkg::PTR_W)
	) u_store (
		.clk(clk),
		.we(mem_we),
		.waddr(wp_q),
		.wdata(req.data.rx_byte),
		.re(rd_go),
		.raddr(rd_addr),
		.rdata(mem_rdata)
	);

	// status fields always come from the state after this item
	assign newest_out = (unread_nxt != '0) ? newest_nxt : 8'd0;

	always_comb begin
		state_nxt = state_q;
		out_load = 1'b0;
		out_d.read_byte = 8'd0;
		out_d.read_valid = 1'b0;
		out_d.timeout_event = 1'b0;
		out_d.pending_count = rrb_pkg::sat_count(unread_nxt);
		out_d.link_busy = (idle_nxt != 16'd0);
		out_d.newest_byte = newest_out;
		out_d.newest_matches = (newest_out == match_q);
		case (state_q)
			rrb_pkg::ST_IDLE: begin
				if (accept) begin
					if (rd_go) begin
						state_nxt = rrb_pkg::ST_READ;
					end else begin
						out_load = 1'b1;
						out_d.timeout_event = tevent;
					end
				end
			end
			rrb_pkg::ST_READ: begin
				out_load = 1'b1;
				out_d.read_byte = mem_rdata;
				out_d.read_valid = 1'b1;
				state_nxt = rrb_pkg::ST_IDLE;
			end
			default: state_nxt = rrb_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrb_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			unread_q <= '0;
			idle_q <= 16'd0;
			out_valid_q <= 1'b0;
		end else begin
			wp_q <= wp_nxt;
			unread_q <= unread_nxt;
			idle_q <= idle_nxt;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		newest_q <= newest_nxt;
		if (out_load) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= 16'd0;
			match_q <= 8'd0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.data.index)
				rrb_pkg::REG_TIMEOUT_TICKS: timeout_q <= cfg.data.value;
				rrb_pkg::REG_MATCH_SYMBOL: match_q <= cfg.data.value[7:0];
				default: ;
			endcase
		end
	end

	// read data lands in an empty result slot
	`RRB_ASSERT(a_read_slot_free, clk, arst_n, (state_q == rrb_pkg::ST_READ) |-> !out_valid_q)
	`RRB_ASSERT(a_read_pops, clk, arst_n, rd_go |=> (state_q == rrb_pkg::ST_READ))
	`RRB_NEVER(a_unread_bound, clk, arst_n, unread_q > LAST_POS)
	`RRB_NEVER(a_wp_bound, clk, arst_n, wp_q > LAST_POS)
	`RRB_NEVER(a_timeout_idle, clk, arst_n, out_valid_q && out_q.timeout_event && out_q.link_busy)
endmodule
`default_nettype wire
